FILE: rtl/dtbp_pkg.sv
// Package for the devicetree blob token parser.
// Holds parse phase codes, token and event codes and the state/event structs.
// No dependencies.
`default_nettype none

package dtbp_pkg;

   localparam logic [31:0] BLOB_MAGIC = 32'hD00D_FEED;

   localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
   localparam logic [31:0] TOK_END_NODE   = 32'd2;
   localparam logic [31:0] TOK_PROP       = 32'd3;
   localparam logic [31:0] TOK_NOP        = 32'd4;
   localparam logic [31:0] TOK_END        = 32'd9;

   localparam logic [29:0] HDR_WORDS        = 30'd10;
   localparam logic [29:0] HDR_POS_MAGIC    = 30'd0;
   localparam logic [29:0] HDR_POS_TOTAL    = 30'd1;
   localparam logic [29:0] HDR_POS_OFF_STR  = 30'd2;
   localparam logic [29:0] HDR_POS_VERSION  = 30'd5;
   localparam logic [29:0] HDR_POS_SIZE_STR = 30'd9;

   localparam logic [3:0] PH_HDR     = 4'd0;
   localparam logic [3:0] PH_WAIT    = 4'd1;
   localparam logic [3:0] PH_TOKEN   = 4'd2;
   localparam logic [3:0] PH_NAME    = 4'd3;
   localparam logic [3:0] PH_PLEN    = 4'd4;
   localparam logic [3:0] PH_PNAME   = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_DONE    = 4'd7;
   localparam logic [3:0] PH_HDR_BAD = 4'd8;

   localparam logic [2:0] EV_BEGIN_NODE = 3'd0;
   localparam logic [2:0] EV_END_NODE   = 3'd1;
   localparam logic [2:0] EV_PROP       = 3'd2;
   localparam logic [2:0] EV_END        = 3'd3;
   localparam logic [2:0] EV_BAD_HEADER = 3'd4;
   localparam logic [2:0] EV_BAD_TOKEN  = 3'd5;
   localparam logic [2:0] EV_OVERRUN    = 3'd6;

   typedef struct packed {
      logic [3:0]  phase;
      logic [29:0] word_position;
      logic [29:0] struct_start_word;
      logic [30:0] struct_end_word;
      logic [31:0] blob_total_size;
      logic [31:0] pending_length;
      logic [31:0] pending_name_offset;
      logic [30:0] payload_words_left;
      logic        payload_first;
   } parse_state_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  code;
      logic [31:0] name_offset;
      logic [31:0] value_length;
      logic [31:0] first_value;
      logic [31:0] info;
   } parse_event_type;

endpackage

`default_nettype wire

FILE: rtl/devicetree_blob_token_parser.sv
// Top level of the devicetree blob token parser: request register, parse
// state, CSR and response register. Depends on dtbp_pkg and dtbp_walker.
//
// Feed a flattened devicetree blob as big-endian 32-bit words from offset 0,
// raising req_start_of_blob on the first word to restart parsing. One word is
// taken every cycle while rsp_stall is low; each word passes a request
// register, one pass of the walker logic and the response register, which
// holds its event. The only loops are the parse-state and depth registers,
// each updated once per word. Words that raise no event produce no response.
// After an end, bad-header or overrun event, words are ignored until the next
// start of blob. csr_wr_data sets the header version to accept (17 after
// reset); write it only while the block is idle.
`default_nettype none

module devicetree_blob_token_parser #(
   parameter int DEPTH_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_blob_word,
   input  logic        req_start_of_blob,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_nest_depth,
   output logic [31:0] rsp_name_offset,
   output logic [31:0] rsp_value_length,
   output logic [31:0] rsp_first_value,
   output logic [31:0] rsp_info
);

   logic [31:0] version_ff;
   logic        in_valid_ff;
   logic [31:0] in_word_ff;
   logic        in_start_ff;
   dtbp_pkg::parse_state_type state_ff;
   dtbp_pkg::parse_state_type state_in;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic [DEPTH_BITS-1:0] depth_in;
   dtbp_pkg::parse_event_type event_in;
   dtbp_pkg::parse_event_type rsp_ff;
   logic [7:0]  rsp_depth_ff;
   logic        rsp_valid_ff;
   logic        fire;
   logic        accept;

   assign fire = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept = req_valid && !req_stall;

   dtbp_walker #(
      .DEPTH_BITS(DEPTH_BITS)
   ) u_walker (
      .cur_state       (state_ff),
      .cur_depth       (depth_ff),
      .expected_version(version_ff),
      .word            (in_word_ff),
      .start_of_blob   (in_start_ff),
      .next_state      (state_in),
      .next_depth      (depth_in),
      .event_out       (event_in)
   );

   // all-zero parse state is the header phase
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 32'd17;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
         depth_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            version_ff <= csr_wr_data;
         end
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            state_ff <= state_in;
            depth_ff <= depth_in;
            rsp_valid_ff <= event_in.valid;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_blob_word;
         in_start_ff <= req_start_of_blob;
      end
      if (fire && event_in.valid) begin
         rsp_ff <= event_in;
         rsp_depth_ff <= 8'(depth_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_res = rsp_ff.code;
   assign rsp_nest_depth = rsp_depth_ff;
   assign rsp_name_offset = rsp_ff.name_offset;
   assign rsp_value_length = rsp_ff.value_length;
   assign rsp_first_value = rsp_ff.first_value;
   assign rsp_info = rsp_ff.info;

endmodule

`default_nettype wire

FILE: rtl/dtbp_walker.sv
// Next-state and event logic of the devicetree blob parser for one word.
// Purely combinational; depends on dtbp_pkg.
`default_nettype none

module dtbp_walker #(
   parameter int DEPTH_BITS = 8
) (
   input  dtbp_pkg::parse_state_type cur_state,
   input  logic [DEPTH_BITS-1:0]     cur_depth,
   input  logic [31:0]               expected_version,
   input  logic [31:0]               word,
   input  logic                      start_of_blob,
   output dtbp_pkg::parse_state_type next_state,
   output logic [DEPTH_BITS-1:0]     next_depth,
   output dtbp_pkg::parse_event_type event_out
);

   dtbp_pkg::parse_state_type s;
   logic [DEPTH_BITS-1:0] d;
   logic                  overrun;
   logic                  do_token;
   logic                  zero_byte;
   logic [32:0]           end_sum;
   logic [32:0]           len_round;
   logic [30:0]           words_total;
   logic [30:0]           left_dec;

   always_comb begin
      if (start_of_blob) begin
         s = '0;
         s.phase = dtbp_pkg::PH_HDR;
         d = '0;
      end else begin
         s = cur_state;
         d = cur_depth;
      end
   end

   assign overrun = ({1'b0, s.word_position} + 31'd1) > s.struct_end_word;
   assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                      (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
   assign end_sum = {1'b0, s.struct_start_word, 2'b00} + {31'd0, s.struct_end_word[1:0]}
                    + {1'b0, word};
   assign len_round = {1'b0, s.pending_length} + 33'd3;
   assign words_total = len_round[32:2];
   assign left_dec = s.payload_words_left - 31'd1;

   always_comb begin
      next_state = s;
      next_depth = d;
      event_out = '0;
      do_token = 1'b0;
      if (s.word_position != '1) begin
         next_state.word_position = s.word_position + 30'd1;
      end

      case (s.phase)
         dtbp_pkg::PH_HDR, dtbp_pkg::PH_HDR_BAD: begin
            if (s.word_position == dtbp_pkg::HDR_POS_MAGIC) begin
               next_state.phase = (word == dtbp_pkg::BLOB_MAGIC) ? dtbp_pkg::PH_HDR
                                                                 : dtbp_pkg::PH_HDR_BAD;
            end else if (s.word_position == dtbp_pkg::HDR_POS_TOTAL) begin
               next_state.blob_total_size = word;
            end else if (s.word_position == dtbp_pkg::HDR_POS_OFF_STR) begin
               next_state.struct_start_word = word[31:2];
               next_state.struct_end_word = {29'd0, word[1:0]};
            end else if (s.word_position == dtbp_pkg::HDR_POS_VERSION) begin
               if (word != expected_version) begin
                  next_state.phase = dtbp_pkg::PH_HDR_BAD;
               end
            end else if (s.word_position == dtbp_pkg::HDR_POS_SIZE_STR) begin
               next_state.struct_end_word = end_sum[32:2];
               if (s.phase == dtbp_pkg::PH_HDR_BAD ||
                   s.struct_start_word < dtbp_pkg::HDR_WORDS) begin
                  next_state.phase = dtbp_pkg::PH_DONE;
                  event_out.valid = 1'b1;
                  event_out.code = dtbp_pkg::EV_BAD_HEADER;
                  event_out.info = s.blob_total_size;
               end else begin
                  next_state.phase = dtbp_pkg::PH_WAIT;
               end
            end
         end
         dtbp_pkg::PH_WAIT: begin
            if (s.word_position >= s.struct_start_word) begin
               next_state.phase = dtbp_pkg::PH_TOKEN;
               do_token = 1'b1;
            end
         end
         dtbp_pkg::PH_TOKEN: begin
            do_token = 1'b1;
         end
         dtbp_pkg::PH_NAME: begin
            if (zero_byte) begin
               next_state.phase = dtbp_pkg::PH_TOKEN;
               if (overrun) begin
                  next_state.phase = dtbp_pkg::PH_DONE;
                  event_out.valid = 1'b1;
                  event_out.code = dtbp_pkg::EV_OVERRUN;
               end
            end
         end
         dtbp_pkg::PH_PLEN: begin
            next_state.pending_length = word;
            next_state.phase = dtbp_pkg::PH_PNAME;
         end
         dtbp_pkg::PH_PNAME: begin
            next_state.pending_name_offset = word;
            next_state.payload_words_left = words_total;
            if (words_total == 31'd0) begin
               next_state.phase = dtbp_pkg::PH_TOKEN;
               event_out.valid = 1'b1;
               if (overrun) begin
                  next_state.phase = dtbp_pkg::PH_DONE;
                  event_out.code = dtbp_pkg::EV_OVERRUN;
               end else begin
                  event_out.code = dtbp_pkg::EV_PROP;
                  event_out.name_offset = word;
                  event_out.value_length = s.pending_length;
               end
            end else begin
               next_state.phase = dtbp_pkg::PH_PAYLOAD;
               next_state.payload_first = 1'b1;
            end
         end
         dtbp_pkg::PH_PAYLOAD: begin
            next_state.payload_words_left = left_dec;
            next_state.payload_first = 1'b0;
            if (left_dec == 31'd0 && overrun) begin
               next_state.phase = dtbp_pkg::PH_DONE;
               event_out.valid = 1'b1;
               event_out.code = dtbp_pkg::EV_OVERRUN;
            end else begin
               if (left_dec == 31'd0) begin
                  next_state.phase = dtbp_pkg::PH_TOKEN;
               end
               if (s.payload_first) begin
                  event_out.valid = 1'b1;
                  event_out.code = dtbp_pkg::EV_PROP;
                  event_out.name_offset = s.pending_name_offset;
                  event_out.value_length = s.pending_length;
                  event_out.first_value = word;
               end
            end
         end
         default: begin
         end
      endcase

      if (do_token) begin
         case (word)
            dtbp_pkg::TOK_BEGIN_NODE: begin
               if (d != '1) begin
                  next_depth = d + DEPTH_BITS'(1);
               end
               next_state.phase = dtbp_pkg::PH_NAME;
               event_out.valid = 1'b1;
               event_out.code = dtbp_pkg::EV_BEGIN_NODE;
            end
            dtbp_pkg::TOK_PROP: begin
               next_state.phase = dtbp_pkg::PH_PLEN;
            end
            dtbp_pkg::TOK_END_NODE: begin
               if (d != '0) begin
                  next_depth = d - DEPTH_BITS'(1);
               end
               event_out.valid = 1'b1;
               event_out.code = dtbp_pkg::EV_END_NODE;
            end
            dtbp_pkg::TOK_NOP: begin
            end
            dtbp_pkg::TOK_END: begin
               next_state.phase = dtbp_pkg::PH_DONE;
               event_out.valid = 1'b1;
               event_out.code = dtbp_pkg::EV_END;
               event_out.info = s.blob_total_size;
            end
            default: begin
               event_out.valid = 1'b1;
               event_out.code = dtbp_pkg::EV_BAD_TOKEN;
               event_out.info = word;
            end
         endcase
         // overrun wins over anything but a begin-node or prop token
         if (overrun && word != dtbp_pkg::TOK_BEGIN_NODE && word != dtbp_pkg::TOK_PROP) begin
            next_state.phase = dtbp_pkg::PH_DONE;
            event_out = '0;
            event_out.valid = 1'b1;
            event_out.code = dtbp_pkg::EV_OVERRUN;
         end
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for devicetree_blob_token_parser: streams generated
// devicetree blobs and checks every event against an in-bench parse predictor.
// Depends on dtbp_pkg and the parser RTL.

module testbench;

   localparam int DEPTH_MAX   = 255;
   localparam int N_PHASES    = 5;
   // random words per register setting; the deep-nesting blob adds 527 to 530
   localparam int PHASE_WORDS = 220;
   localparam int CALM_FROM   = 800;
   localparam int CALM_TO     = 1500;
   localparam logic [29:0] POS_LIMIT = 30'h3FFF_FFFF;

   typedef struct packed {
      logic [31:0] word;
      logic        sob;
   } queued_word_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [7:0]  depth;
      logic [31:0] name_offset;
      logic [31:0] value_length;
      logic [31:0] first_value;
      logic [31:0] info;
   } event_type;

   typedef enum int {
      BLOB_GOOD, BLOB_OVERRUN, BLOB_BAD_MAGIC, BLOB_BAD_VERSION, BLOB_LOW_OFFSET,
      BLOB_TRUNCATED, BLOB_OPEN_PROP, BLOB_DEEP
   } blob_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_blob_word = '0;
   logic        req_start_of_blob = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_nest_depth;
   logic [31:0] rsp_name_offset;
   logic [31:0] rsp_value_length;
   logic [31:0] rsp_first_value;
   logic [31:0] rsp_info;

   devicetree_blob_token_parser #(.DEPTH_BITS(8)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_blob_word    (req_blob_word),
      .req_start_of_blob(req_start_of_blob),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_nest_depth   (rsp_nest_depth),
      .rsp_name_offset  (rsp_name_offset),
      .rsp_value_length (rsp_value_length),
      .rsp_first_value  (rsp_first_value),
      .rsp_info         (rsp_info)
   );

   // parser shadow state
   logic [3:0]  shadow_phase = dtbp_pkg::PH_HDR;
   logic [29:0] shadow_pos = '0;
   logic [29:0] shadow_start = '0;
   logic [31:0] shadow_end = '0;
   logic [31:0] shadow_total = '0;
   logic [15:0] shadow_depth = '0;
   logic [31:0] shadow_len = '0;
   logic [31:0] shadow_noff = '0;
   logic [32:0] shadow_left = '0;
   logic [31:0] shadow_version = 32'd17;

   queued_word_type blob_words[$];
   event_type       pending_events[$];
   logic [31:0]     body_q[$];
   logic [31:0]     image_q[$];

   queued_word_type drv_item;
   event_type   drv_ev;
   event_type   got;
   event_type   want;
   logic [31:0] next_version;
   int unsigned cycle_no = 0;
   int          words_queued = 0;
   int          words_taken = 0;
   int          mismatches = 0;
   int          csr_writes = 0;
   int          seen_by_code[8];

   always #5 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_no <= cycle_no + 1;

   function automatic bit take_break();
      if (cycle_no >= CALM_FROM && cycle_no < CALM_TO)
         return 1'b0;
      return $urandom_range(99) < 26;
   endfunction

   function automatic void shadow_clear();
      shadow_phase = dtbp_pkg::PH_HDR;
      shadow_pos   = '0;
      shadow_start = '0;
      shadow_end   = '0;
      shadow_total = '0;
      shadow_depth = '0;
      shadow_len   = '0;
      shadow_noff  = '0;
      shadow_left  = '0;
   endfunction

   function automatic bit past_struct_end();
      return ({2'b00, shadow_pos} + 32'd1) > shadow_end;
   endfunction

   function automatic event_type make_event(input logic [2:0] code,
                                            input logic [31:0] noff, len, fv, info);
      event_type ev;
      ev.code         = code;
      ev.depth        = shadow_depth[7:0];
      ev.name_offset  = noff;
      ev.value_length = len;
      ev.first_value  = fv;
      ev.info         = info;
      return ev;
   endfunction

   function automatic event_type overrun_event();
      shadow_phase = dtbp_pkg::PH_DONE;
      return make_event(dtbp_pkg::EV_OVERRUN, 32'd0, 32'd0, 32'd0, 32'd0);
   endfunction

   function automatic bit shadow_token(input logic [31:0] w, output event_type ev);
      ev = '0;
      case (w)
         dtbp_pkg::TOK_BEGIN_NODE: begin
            if (shadow_depth < DEPTH_MAX)
               shadow_depth++;
            shadow_phase = dtbp_pkg::PH_NAME;
            ev = make_event(dtbp_pkg::EV_BEGIN_NODE, 32'd0, 32'd0, 32'd0, 32'd0);
            return 1'b1;
         end
         dtbp_pkg::TOK_PROP: begin
            shadow_phase = dtbp_pkg::PH_PLEN;
            return 1'b0;
         end
         dtbp_pkg::TOK_END_NODE: begin
            if (shadow_depth > 0)
               shadow_depth--;
            ev = make_event(dtbp_pkg::EV_END_NODE, 32'd0, 32'd0, 32'd0, 32'd0);
         end
         dtbp_pkg::TOK_NOP: ;
         dtbp_pkg::TOK_END:
            ev = make_event(dtbp_pkg::EV_END, 32'd0, 32'd0, 32'd0, shadow_total);
         default: ev = make_event(dtbp_pkg::EV_BAD_TOKEN, 32'd0, 32'd0, 32'd0, w);
      endcase
      if (past_struct_end()) begin
         ev = overrun_event();
         return 1'b1;
      end
      if (w == dtbp_pkg::TOK_NOP)
         return 1'b0;
      if (w == dtbp_pkg::TOK_END)
         shadow_phase = dtbp_pkg::PH_DONE;
      return 1'b1;
   endfunction

   // Advances the shadow parser by one word; returns 1 when an event is due.
   function automatic bit shadow_word(input logic [31:0] w, input logic sob,
                                      output event_type ev);
      bit          hit;
      logic [32:0] sum;
      logic [32:0] words_total;
      hit = 1'b0;
      ev  = '0;
      if (sob)
         shadow_clear();
      case (shadow_phase)
         dtbp_pkg::PH_HDR, dtbp_pkg::PH_HDR_BAD: begin
            if (shadow_pos == dtbp_pkg::HDR_POS_MAGIC) begin
               shadow_phase = (w == dtbp_pkg::BLOB_MAGIC) ? dtbp_pkg::PH_HDR
                                                          : dtbp_pkg::PH_HDR_BAD;
            end else if (shadow_pos == dtbp_pkg::HDR_POS_TOTAL) begin
               shadow_total = w;
            end else if (shadow_pos == dtbp_pkg::HDR_POS_OFF_STR) begin
               shadow_start = w[31:2];
               shadow_end   = {30'd0, w[1:0]};
            end else if (shadow_pos == dtbp_pkg::HDR_POS_VERSION) begin
               if (w != shadow_version)
                  shadow_phase = dtbp_pkg::PH_HDR_BAD;
            end else if (shadow_pos == dtbp_pkg::HDR_POS_SIZE_STR) begin
               sum = {1'b0, shadow_start, 2'b00} + {31'd0, shadow_end[1:0]} + {1'b0, w};
               shadow_end = {1'b0, sum[32:2]};
               if (shadow_phase == dtbp_pkg::PH_HDR_BAD ||
                   shadow_start < dtbp_pkg::HDR_WORDS) begin
                  shadow_phase = dtbp_pkg::PH_DONE;
                  ev  = make_event(dtbp_pkg::EV_BAD_HEADER, 32'd0, 32'd0, 32'd0,
                                   shadow_total);
                  hit = 1'b1;
               end else begin
                  shadow_phase = dtbp_pkg::PH_WAIT;
               end
            end
         end
         dtbp_pkg::PH_WAIT: begin
            if (shadow_pos >= shadow_start) begin
               shadow_phase = dtbp_pkg::PH_TOKEN;
               hit = shadow_token(w, ev);
            end
         end
         dtbp_pkg::PH_TOKEN: hit = shadow_token(w, ev);
         dtbp_pkg::PH_NAME: begin
            if (w[31:24] == 0 || w[23:16] == 0 || w[15:8] == 0 || w[7:0] == 0) begin
               shadow_phase = dtbp_pkg::PH_TOKEN;
               if (past_struct_end()) begin
                  ev  = overrun_event();
                  hit = 1'b1;
               end
            end
         end
         dtbp_pkg::PH_PLEN: begin
            shadow_len   = w;
            shadow_phase = dtbp_pkg::PH_PNAME;
         end
         dtbp_pkg::PH_PNAME: begin
            shadow_noff = w;
            shadow_left = ({1'b0, shadow_len} + 33'd3) >> 2;
            if (shadow_left == 0) begin
               shadow_phase = dtbp_pkg::PH_TOKEN;
               hit = 1'b1;
               if (past_struct_end())
                  ev = overrun_event();
               else
                  ev = make_event(dtbp_pkg::EV_PROP, shadow_noff, shadow_len, 32'd0,
                                  32'd0);
            end else begin
               shadow_phase = dtbp_pkg::PH_PAYLOAD;
            end
         end
         dtbp_pkg::PH_PAYLOAD: begin
            words_total = ({1'b0, shadow_len} + 33'd3) >> 2;
            if (shadow_left == words_total) begin
               ev  = make_event(dtbp_pkg::EV_PROP, shadow_noff, shadow_len, w, 32'd0);
               hit = 1'b1;
            end
            shadow_left--;
            if (shadow_left == 0) begin
               shadow_phase = dtbp_pkg::PH_TOKEN;
               if (past_struct_end()) begin
                  ev  = overrun_event();
                  hit = 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (shadow_pos != POS_LIMIT)
         shadow_pos++;
      return hit;
   endfunction

   task automatic queue_word(input logic [31:0] w, input logic sob, input bit counts);
      queued_word_type item;
      item.word = w;
      item.sob  = sob;
      blob_words.push_back(item);
      if (counts)
         words_queued++;
   endtask

   function automatic logic [31:0] solid_word();
      logic [31:0] w;
      for (int i = 0; i < 4; i++)
         w[8*i +: 8] = $urandom_range(255, 1);
      return w;
   endfunction

   function automatic logic [31:0] odd_token();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return $urandom_range(8, 5);
         2: return $urandom_range(255, 10);
         default: return $urandom | 32'h10;
      endcase
   endfunction

   task automatic build_body(input int n_tok);
      int          depth_now;
      int          len;
      int          pick;
      int          k;
      logic [31:0] w;
      body_q.delete();
      depth_now = 0;
      for (int t = 0; t < n_tok; t++) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            body_q.push_back(dtbp_pkg::TOK_BEGIN_NODE);
            repeat ($urandom_range(2)) body_q.push_back(solid_word());
            w = solid_word();
            k = $urandom_range(3);
            w[8*k +: 8] = 8'h00;
            body_q.push_back(w);
            depth_now++;
         end else if (pick < 55) begin
            len = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 1);
            body_q.push_back(dtbp_pkg::TOK_PROP);
            body_q.push_back(len);
            body_q.push_back($urandom);
            repeat ((len + 3) / 4) body_q.push_back($urandom);
         end else if (pick < 75) begin
            if (depth_now > 0 || $urandom_range(3) == 0) begin
               body_q.push_back(dtbp_pkg::TOK_END_NODE);
               if (depth_now > 0)
                  depth_now--;
            end else begin
               body_q.push_back(dtbp_pkg::TOK_NOP);
            end
         end else if (pick < 88) begin
            body_q.push_back(dtbp_pkg::TOK_NOP);
         end else begin
            body_q.push_back(odd_token());
         end
      end
      repeat (depth_now) body_q.push_back(dtbp_pkg::TOK_END_NODE);
      body_q.push_back(dtbp_pkg::TOK_END);
   endtask

   task automatic queue_blob(input blob_kind_type kind, input logic sob);
      logic [31:0] off_struct;
      logic [31:0] size_struct;
      logic [31:0] len;
      int          start_word;
      int          cut;
      image_q.delete();
      if (kind == BLOB_DEEP) begin
         body_q.delete();
         repeat (DEPTH_MAX + 3) begin
            body_q.push_back(dtbp_pkg::TOK_BEGIN_NODE);
            body_q.push_back(32'h0);
         end
         body_q.push_back(dtbp_pkg::TOK_END);
      end else begin
         build_body($urandom_range(14, 3));
      end
      if (kind == BLOB_OPEN_PROP) begin
         // property left open: the payload runs past the end of the stream
         void'(body_q.pop_back());
         len = $urandom;
         if (len < 16)
            len = len + 16;
         body_q.push_back(dtbp_pkg::TOK_PROP);
         body_q.push_back(len);
         body_q.push_back($urandom);
         repeat ($urandom_range(3, 1)) body_q.push_back($urandom);
      end
      start_word = 10 + $urandom_range(3);
      off_struct = 4 * start_word + (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
      if (kind == BLOB_LOW_OFFSET)
         off_struct = $urandom_range(39);
      size_struct = 4 * body_q.size();
      if (kind == BLOB_OVERRUN)
         size_struct = $urandom_range(size_struct - 1);
      if (kind == BLOB_OPEN_PROP)
         size_struct = $urandom | 32'h8000_0000;

      image_q.push_back(kind == BLOB_BAD_MAGIC
                        ? dtbp_pkg::BLOB_MAGIC ^ (32'd1 << $urandom_range(31))
                        : dtbp_pkg::BLOB_MAGIC);
      image_q.push_back($urandom);
      image_q.push_back(off_struct);
      repeat (2) image_q.push_back($urandom);
      image_q.push_back(kind == BLOB_BAD_VERSION
                        ? shadow_version ^ (32'd1 << $urandom_range(31)) : shadow_version);
      repeat (3) image_q.push_back($urandom);
      image_q.push_back(size_struct);
      if (kind != BLOB_BAD_MAGIC && kind != BLOB_BAD_VERSION && kind != BLOB_LOW_OFFSET) begin
         repeat (start_word - 10) image_q.push_back($urandom);
         foreach (body_q[i]) image_q.push_back(body_q[i]);
      end

      cut = (kind == BLOB_TRUNCATED) ? $urandom_range(image_q.size() - 1, 1) : image_q.size();
      for (int i = 0; i < cut; i++)
         queue_word(image_q[i], (i == 0) ? sob : 1'b0, 1'b1);
      // trailing words after a finished blob are ignored by the parser
      if (kind != BLOB_TRUNCATED && kind != BLOB_OPEN_PROP)
         repeat ($urandom_range(2)) queue_word($urandom, 1'b0, 1'b0);
   endtask

   task automatic queue_noise();
      int n;
      n = $urandom_range(12, 3);
      queue_word($urandom, 1'b1, 1'b1);
      repeat (n - 1) queue_word($urandom, $urandom_range(7) == 0, 1'b1);
   endtask

   task automatic queue_random(input int upto);
      int pick;
      while (words_queued < upto) begin
         pick = $urandom_range(99);
         if (pick < 55)
            queue_blob(BLOB_GOOD, 1'b1);
         else if (pick < 65)
            queue_blob(BLOB_OVERRUN, 1'b1);
         else if (pick < 70)
            queue_blob(BLOB_BAD_MAGIC, 1'b1);
         else if (pick < 75)
            queue_blob(BLOB_BAD_VERSION, 1'b1);
         else if (pick < 80)
            queue_blob(BLOB_LOW_OFFSET, 1'b1);
         else if (pick < 87)
            queue_blob(BLOB_TRUNCATED, 1'b1);
         else if (pick < 92)
            queue_blob(BLOB_OPEN_PROP, 1'b1);
         else
            queue_noise();
      end
   endtask

   // Compact blob parsed straight from reset, no start marker.
   task automatic queue_directed();
      logic [31:0] seed_blob [25];
      seed_blob = '{dtbp_pkg::BLOB_MAGIC, 32'hFFFF_FFFF, 32'd40, 32'd200, 32'd16,
                    32'd17, 32'd16, 32'd0, 32'd32, 32'd60,
                    dtbp_pkg::TOK_BEGIN_NODE, 32'h6162_6300,
                    dtbp_pkg::TOK_PROP, 32'd0, 32'hFFFF_FFFF,
                    dtbp_pkg::TOK_PROP, 32'd5, 32'd0, 32'h0123_4567, 32'h89AB_CDEF,
                    dtbp_pkg::TOK_NOP, dtbp_pkg::TOK_END_NODE, dtbp_pkg::TOK_END_NODE,
                    32'hFFFF_FFFF, dtbp_pkg::TOK_END};
      foreach (seed_blob[i])
         queue_word(seed_blob[i], 1'b0, 1'b1);
   endtask

   task automatic drain();
      while (blob_words.size() != 0 || req_valid || pending_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_version(input logic [31:0] v);
      drain();
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= v;
      shadow_version  = v;
      csr_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            words_taken++;
            if (shadow_word(req_blob_word, req_start_of_blob, drv_ev))
               pending_events.push_back(drv_ev);
         end
         if (!req_valid || !req_stall) begin
            if (blob_words.size() != 0 && !take_break()) begin
               drv_item = blob_words.pop_front();
               req_valid         <= 1'b1;
               req_blob_word     <= drv_item.word;
               req_start_of_blob <= drv_item.sob;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_event_res, rsp_nest_depth, rsp_name_offset, rsp_value_length,
                   rsp_first_value, rsp_info};
            if (pending_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: unexpected event code %0d depth %0d info %h",
                           $realtime, got.code, got.depth, got.info);
            end else begin
               want = pending_events.pop_front();
               seen_by_code[want.code]++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%t: expected ev %0d dep %0d noff %h len %h fv %h info %h, %s",
                              $realtime, want.code, want.depth, want.name_offset,
                              want.value_length, want.first_value, want.info,
                              $sformatf("got ev %0d dep %0d noff %h len %h fv %h info %h",
                                        got.code, got.depth, got.name_offset,
                                        got.value_length, got.first_value, got.info));
               end
            end
         end
         rsp_stall <= take_break();
      end
   end

   initial begin
      queue_directed();
      queue_random(words_queued + PHASE_WORDS);
      for (int p = 1; p < N_PHASES; p++) begin
         case (p)
            1: next_version = 32'hFFFF_FFFF;
            2: next_version = 32'h0000_0000;
            3: next_version = $urandom;
            default: next_version = 32'd17;
         endcase
         write_version(next_version);
         if (p == 1)
            queue_blob(BLOB_DEEP, 1'b1);
         queue_random(words_queued + PHASE_WORDS);
      end
      drain();
      repeat (10) @(posedge clock);
      $display("Streamed %0d blob words under %0d version settings; events: node %0d/%0d,",
               words_taken, csr_writes + 1, seen_by_code[dtbp_pkg::EV_BEGIN_NODE],
               seen_by_code[dtbp_pkg::EV_END_NODE]);
      $display("  prop %0d, end %0d, bad header %0d, bad token %0d, overrun %0d",
               seen_by_code[dtbp_pkg::EV_PROP], seen_by_code[dtbp_pkg::EV_END],
               seen_by_code[dtbp_pkg::EV_BAD_HEADER], seen_by_code[dtbp_pkg::EV_BAD_TOKEN],
               seen_by_code[dtbp_pkg::EV_OVERRUN]);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
